FILE: src/dmgps_pkg.sv
`timescale 1ns / 1ps

package dmgps_pkg;

  localparam int unsigned WORK_TIMEOUT_MS  = 1200;
  localparam int unsigned PRESS_DONE_SPEED = 128;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned PROD_W = 26;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_PEAKS  = 2'd1,
    KIND_DEACT  = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_AUTO_ENABLE   = 3'd0,
    REG_ACT_THRESHOLD = 3'd1,
    REG_TRIGGER_SPEED = 3'd2,
    REG_WAIT_MS       = 3'd3,
    REG_IDLE_MS       = 3'd4,
    REG_LIFT_TIMEOUT  = 3'd5,
    REG_PRESS_TIMEOUT = 3'd6,
    REG_VEL_SCALE     = 3'd7
  } reg_index_t;

  localparam logic [1:0] MOTOR_NONE = 2'd0;
  localparam logic [1:0] MOTOR_1    = 2'd1;
  localparam logic [1:0] MOTOR_2    = 2'd2;

  localparam logic [1:0] CH_NONE = 2'd0;
  localparam logic [1:0] CH_6    = 2'd1;
  localparam logic [1:0] CH_7    = 2'd2;

  localparam logic [1:0] PROF_IDLE  = 2'd0;
  localparam logic [1:0] PROF_LIFT  = 2'd1;
  localparam logic [1:0] PROF_PRESS = 2'd2;

  // One queued command group: an optional pair of idle commands to both
  // motors, then an optional scaled command to one motor.
  typedef struct packed {
    logic                     idle_pair;
    logic                     clr;
    logic                     has_cmd;
    logic [1:0]               cmd_motor;
    logic [1:0]               cmd_profile;
    logic signed [PROD_W-1:0] product;
  } desc_t;

endpackage

FILE: src/dmgps_front.sv
`timescale 1ns / 1ps

module dmgps_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [2:0]             wr_index,
  input  logic [15:0]            wr_data,
  input  logic                   accept,
  input  logic [1:0]             kind,
  input  logic [31:0]            now_ms,
  input  logic [1:0]             motor_id,
  input  logic signed [15:0]     velocity,
  input  logic [15:0]            peak_ch6,
  input  logic [15:0]            peak_ch7,
  output logic                   q_push,
  output dmgps_pkg::desc_t       q_desc
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_WAIT  = 3'd1,
    ST_LIFT  = 3'd2,
    ST_PRESS = 3'd3,
    ST_WORK1 = 3'd4,
    ST_WORK2 = 3'd5
  } phase_t;

  logic        auto_enable;
  logic [15:0] activation_threshold;
  logic [14:0] trigger_speed;
  logic [15:0] wait_ms;
  logic [15:0] idle_ms;
  logic [15:0] lift_timeout_ms;
  logic [15:0] press_timeout_ms;
  logic [8:0]  velocity_scale;

  phase_t             phase, phase_next;
  logic               engaged, engaged_next;
  logic [1:0]         armed_channel, armed_channel_next;
  logic [1:0]         lifting_motor, lifting_motor_next;
  logic [1:0]         next_worker, next_worker_next;
  logic signed [15:0] captured_velocity, captured_velocity_next;
  logic [31:0]        phase_start, phase_start_next;
  logic [31:0]        wait_start, wait_start_next;
  logic [31:0]        work_start, work_start_next;

  logic signed [16:0] v_ext, t_pos, t_neg, pd_pos, pd_neg;
  logic               above, below, near_zero, id_match, a6, a7, go;
  logic [31:0]        phase_dur, wait_dur, work_dur;
  dmgps_pkg::desc_t   desc;

  assign v_ext     = {velocity[15], velocity};
  assign t_pos     = $signed({2'b00, trigger_speed});
  assign t_neg     = -t_pos;
  assign pd_pos    = 17'(dmgps_pkg::PRESS_DONE_SPEED);
  assign pd_neg    = -pd_pos;
  assign above     = v_ext > t_pos;
  assign below     = v_ext < t_neg;
  assign near_zero = (v_ext > pd_neg) && (v_ext < pd_pos);
  assign id_match  = ((lifting_motor == dmgps_pkg::MOTOR_1) && (motor_id == dmgps_pkg::MOTOR_1))
                  || ((lifting_motor == dmgps_pkg::MOTOR_2) && (motor_id == dmgps_pkg::MOTOR_2));
  assign a6        = peak_ch6 > activation_threshold;
  assign a7        = peak_ch7 > activation_threshold;
  assign phase_dur = now_ms - phase_start;
  assign wait_dur  = now_ms - wait_start;
  assign work_dur  = now_ms - work_start;

  always_comb begin
    phase_next             = phase;
    engaged_next           = engaged;
    armed_channel_next     = armed_channel;
    lifting_motor_next     = lifting_motor;
    next_worker_next       = next_worker;
    captured_velocity_next = captured_velocity;
    phase_start_next       = phase_start;
    wait_start_next        = wait_start;
    work_start_next        = work_start;
    go                     = 1'b0;
    desc                   = '0;
    desc.product = dmgps_pkg::PROD_W'(velocity)
                 * dmgps_pkg::PROD_W'($signed({1'b0, velocity_scale}));

    if (accept) begin
      case (kind)
        dmgps_pkg::KIND_PEAKS: begin
          if (auto_enable && !engaged && (a6 || a7)) begin
            if (a6 && a7) begin
              armed_channel_next = (peak_ch6 > peak_ch7) ? dmgps_pkg::CH_6 : dmgps_pkg::CH_7;
            end else begin
              armed_channel_next = a6 ? dmgps_pkg::CH_6 : dmgps_pkg::CH_7;
            end
            engaged_next    = 1'b1;
            phase_next      = ST_WAIT;
            wait_start_next = now_ms;
          end
        end
        dmgps_pkg::KIND_DEACT: begin
          if (engaged) begin
            engaged_next       = 1'b0;
            phase_next         = ST_IDLE;
            armed_channel_next = dmgps_pkg::CH_NONE;
            wait_start_next    = '0;
            work_start_next    = '0;
          end
        end
        dmgps_pkg::KIND_SAMPLE: begin
          if (engaged) begin
            case (phase)
              ST_WAIT: begin
                desc.idle_pair = 1'b1;
                if (wait_dur >= {16'b0, wait_ms}) begin
                  if ((armed_channel == dmgps_pkg::CH_6) && (motor_id == dmgps_pkg::MOTOR_2)
                      && below) begin
                    next_worker_next   = dmgps_pkg::MOTOR_1;
                    lifting_motor_next = dmgps_pkg::MOTOR_2;
                    go                 = 1'b1;
                  end else if ((armed_channel == dmgps_pkg::CH_7)
                               && (motor_id == dmgps_pkg::MOTOR_1) && above) begin
                    next_worker_next   = dmgps_pkg::MOTOR_2;
                    lifting_motor_next = dmgps_pkg::MOTOR_1;
                    go                 = 1'b1;
                  end
                end
              end
              ST_WORK1, ST_WORK2: begin
                desc.idle_pair = 1'b1;
                if (work_dur >= 32'(dmgps_pkg::WORK_TIMEOUT_MS)) begin
                  desc.clr           = 1'b1;
                  engaged_next       = 1'b0;
                  phase_next         = ST_IDLE;
                  armed_channel_next = dmgps_pkg::CH_NONE;
                  wait_start_next    = '0;
                  work_start_next    = '0;
                end else if ((phase == ST_WORK1) && (motor_id == dmgps_pkg::MOTOR_1)
                             && above) begin
                  lifting_motor_next = dmgps_pkg::MOTOR_1;
                  go                 = 1'b1;
                end else if ((phase == ST_WORK2) && (motor_id == dmgps_pkg::MOTOR_2)
                             && below) begin
                  lifting_motor_next = dmgps_pkg::MOTOR_2;
                  go                 = 1'b1;
                end
              end
              ST_LIFT: begin
                if (phase_dur >= {16'b0, lift_timeout_ms}) begin
                  go = 1'b1;
                end else if (id_match && (lifting_motor == dmgps_pkg::MOTOR_1)) begin
                  go = (captured_velocity > 16'sd0) && velocity[15];
                end else if (id_match) begin
                  go = captured_velocity[15] && (velocity > 16'sd0);
                end
                desc.has_cmd   = id_match;
                desc.cmd_motor = lifting_motor;
                if (go) begin
                  next_worker_next = (lifting_motor == dmgps_pkg::MOTOR_1)
                                   ? dmgps_pkg::MOTOR_2 : dmgps_pkg::MOTOR_1;
                  phase_next       = ST_PRESS;
                  phase_start_next = now_ms;
                  desc.cmd_profile = dmgps_pkg::PROF_PRESS;
                end else begin
                  desc.cmd_profile = dmgps_pkg::PROF_LIFT;
                end
                // go here means phase change, not a new lift
                go = 1'b0;
              end
              ST_PRESS: begin
                if ((phase_dur >= {16'b0, press_timeout_ms}) || (id_match && near_zero)) begin
                  phase_next         = ST_IDLE;
                  lifting_motor_next = dmgps_pkg::MOTOR_NONE;
                  phase_start_next   = now_ms;
                  desc.idle_pair     = 1'b1;
                end else begin
                  desc.has_cmd     = id_match;
                  desc.cmd_motor   = lifting_motor;
                  desc.cmd_profile = dmgps_pkg::PROF_PRESS;
                end
              end
              ST_IDLE: begin
                desc.idle_pair = 1'b1;
                if (phase_dur >= {16'b0, idle_ms}) begin
                  phase_next       = (next_worker == dmgps_pkg::MOTOR_1) ? ST_WORK1 : ST_WORK2;
                  phase_start_next = now_ms;
                  work_start_next  = now_ms;
                end
              end
              default: begin
              end
            endcase

            // start of a lift phase: capture and command the lifting motor
            if (go) begin
              captured_velocity_next = velocity;
              phase_next             = ST_LIFT;
              phase_start_next       = now_ms;
              desc.has_cmd           = 1'b1;
              desc.cmd_motor         = lifting_motor_next;
              desc.cmd_profile       = dmgps_pkg::PROF_LIFT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign q_push = desc.idle_pair || desc.has_cmd;
  assign q_desc = desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_enable          <= 1'b0;
      activation_threshold <= 16'd2560;
      trigger_speed        <= 15'd512;
      wait_ms              <= 16'd300;
      idle_ms              <= 16'd100;
      lift_timeout_ms      <= 16'd500;
      press_timeout_ms     <= 16'd350;
      velocity_scale       <= 9'd205;
      phase                <= ST_IDLE;
      engaged              <= 1'b0;
      armed_channel        <= dmgps_pkg::CH_NONE;
      lifting_motor        <= dmgps_pkg::MOTOR_NONE;
      next_worker          <= dmgps_pkg::MOTOR_NONE;
      captured_velocity    <= '0;
      phase_start          <= '0;
      wait_start           <= '0;
      work_start           <= '0;
    end else begin
      phase             <= phase_next;
      engaged           <= engaged_next;
      armed_channel     <= armed_channel_next;
      lifting_motor     <= lifting_motor_next;
      next_worker       <= next_worker_next;
      captured_velocity <= captured_velocity_next;
      phase_start       <= phase_start_next;
      wait_start        <= wait_start_next;
      work_start        <= work_start_next;
      if (wr_en) begin
        case (dmgps_pkg::reg_index_t'(wr_index))
          dmgps_pkg::REG_AUTO_ENABLE: begin
            auto_enable <= wr_data[0];
            // dropping auto disengages without touching the phase
            if (!wr_data[0]) begin
              engaged <= 1'b0;
            end
          end
          dmgps_pkg::REG_ACT_THRESHOLD: activation_threshold <= wr_data;
          dmgps_pkg::REG_TRIGGER_SPEED: trigger_speed        <= wr_data[14:0];
          dmgps_pkg::REG_WAIT_MS:       wait_ms              <= wr_data;
          dmgps_pkg::REG_IDLE_MS:       idle_ms              <= wr_data;
          dmgps_pkg::REG_LIFT_TIMEOUT:  lift_timeout_ms      <= wr_data;
          dmgps_pkg::REG_PRESS_TIMEOUT: press_timeout_ms     <= wr_data;
          dmgps_pkg::REG_VEL_SCALE:     velocity_scale       <= wr_data[8:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: src/dmgps_queue.sv
`timescale 1ns / 1ps

module dmgps_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dmgps_pkg::desc_t push_desc,
  input  logic             pop,
  output dmgps_pkg::desc_t head_desc,
  output logic             not_empty,
  output logic             full
);

  dmgps_pkg::desc_t                  entries [dmgps_pkg::QUEUE_DEPTH];
  logic [dmgps_pkg::QPTR_W-1:0]      wptr, rptr;
  logic [dmgps_pkg::QCNT_W-1:0]      count;
  logic                              do_push, do_pop;

  assign not_empty = count != '0;
  assign full      = count == dmgps_pkg::QCNT_W'(dmgps_pkg::QUEUE_DEPTH);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_desc = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + dmgps_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rptr <= rptr + dmgps_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + dmgps_pkg::QCNT_W'(1);
        2'b01:   count <= count - dmgps_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/dmgps_back.sv
`timescale 1ns / 1ps

module dmgps_back (
  input  logic                clk,
  input  logic                rst,
  input  dmgps_pkg::desc_t    head_desc,
  input  logic                head_valid,
  output logic                head_pop,
  input  logic                pop,
  output logic                empty,
  output logic [1:0]          target_motor,
  output logic [1:0]          profile,
  output logic signed [15:0]  velocity_cmd,
  output logic                clear_buffers,
  output logic                last
);

  dmgps_pkg::desc_t   cur;
  logic               cur_valid;
  logic [1:0]         step;
  logic               out_valid;

  logic               load, cur_last, cur_free;
  logic [1:0]         n_results;
  logic signed [17:0] shifted;
  logic signed [15:0] sat_vel;
  logic [1:0]         r_motor, r_profile;
  logic signed [15:0] r_vel;
  logic               r_clr;

  // floor of product / 256, then clamp to 16 bits
  assign shifted = cur.product[dmgps_pkg::PROD_W-1:8];
  always_comb begin
    if (shifted > 18'sd32767) begin
      sat_vel = 16'sh7FFF;
    end else if (shifted < -18'sd32768) begin
      sat_vel = -16'sh8000;
    end else begin
      sat_vel = shifted[15:0];
    end
  end

  assign n_results = {cur.idle_pair, 1'b0} + {1'b0, cur.has_cmd};
  assign cur_last  = (step + 2'd1) == n_results;
  assign load      = cur_valid && (!out_valid || pop);
  assign cur_free  = !cur_valid || (load && cur_last);
  assign head_pop  = head_valid && cur_free;

  always_comb begin
    if (cur.idle_pair && (step != 2'd2) && !(step == 2'd1 && !cur.idle_pair)) begin
      r_motor   = step[0] ? dmgps_pkg::MOTOR_2 : dmgps_pkg::MOTOR_1;
      r_profile = dmgps_pkg::PROF_IDLE;
      r_vel     = '0;
      r_clr     = cur.clr;
    end else begin
      r_motor   = cur.cmd_motor;
      r_profile = cur.cmd_profile;
      r_vel     = sat_vel;
      r_clr     = 1'b0;
    end
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (head_pop) begin
        cur       <= head_desc;
        cur_valid <= 1'b1;
        step      <= '0;
      end else if (load) begin
        step <= step + 2'd1;
        if (cur_last) begin
          cur_valid <= 1'b0;
        end
      end
      if (load) begin
        out_valid     <= 1'b1;
        target_motor  <= r_motor;
        profile       <= r_profile;
        velocity_cmd  <= r_vel;
        clear_buffers <= r_clr;
        last          <= cur_last;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/dual_motor_gait_phase_sequencer_top.sv
`timescale 1ns / 1ps
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------
// input    | push / full        | kind, now_ms, motor_id, velocity, peak_ch6/7
// result   | empty / pop        | target_motor, profile, velocity_cmd,
//          |                    | clear_buffers, last
// config   | wr_en              | wr_index, wr_data
//
// An item is taken at an edge with push high and full low; state updates at
// that edge and its command group enters a four-deep queue. Results leave
// one per cycle from the output register while pop is held high.
// Synchronous reset clears state and queue and restores register defaults.
// A stalled result side fills the queue, then full rises; pop and push are
// otherwise independent.

module dual_motor_gait_phase_sequencer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         kind,
  input  logic [31:0]        now_ms,
  input  logic [1:0]         motor_id,
  input  logic signed [15:0] velocity,
  input  logic [15:0]        peak_ch6,
  input  logic [15:0]        peak_ch7,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         target_motor,
  output logic [1:0]         profile,
  output logic signed [15:0] velocity_cmd,
  output logic               clear_buffers,
  output logic               last
);

  dmgps_pkg::desc_t push_desc, head_desc;
  logic             q_push, head_valid, head_pop, q_full, accept;

  assign accept = push && !q_full;
  assign full   = q_full;

  dmgps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .accept   (accept),
    .kind     (kind),
    .now_ms   (now_ms),
    .motor_id (motor_id),
    .velocity (velocity),
    .peak_ch6 (peak_ch6),
    .peak_ch7 (peak_ch7),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  dmgps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push && accept),
    .push_desc (push_desc),
    .pop       (head_pop),
    .head_desc (head_desc),
    .not_empty (head_valid),
    .full      (q_full)
  );

  dmgps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_desc     (head_desc),
    .head_valid    (head_valid),
    .head_pop      (head_pop),
    .pop           (pop),
    .empty         (empty),
    .target_motor  (target_motor),
    .profile       (profile),
    .velocity_cmd  (velocity_cmd),
    .clear_buffers (clear_buffers),
    .last          (last)
  );

endmodule

FILE: src/dmgps_checker.sv
`timescale 1ns / 1ps

module dmgps_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic [1:0]         target_motor,
  input logic [1:0]         profile,
  input logic signed [15:0] velocity_cmd,
  input logic               clear_buffers,
  input logic               last
);

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(target_motor) && $stable(profile)
                          && $stable(velocity_cmd) && $stable(last)))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  a_motor: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (target_motor == 2'd1 || target_motor == 2'd2))
    else $error("command to no motor");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && profile == 2'd0) |-> (velocity_cmd == 16'sd0))
    else $error("idle command with velocity");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    (!empty && clear_buffers) |-> (profile == 2'd0))
    else $error("buffer clear on an active command");

endmodule

bind dual_motor_gait_phase_sequencer_top dmgps_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .target_motor  (target_motor),
  .profile       (profile),
  .velocity_cmd  (velocity_cmd),
  .clear_buffers (clear_buffers),
  .last          (last)
);

FILE: verif/tb_dual_motor_gait_phase_sequencer_top.sv
`timescale 1ns / 1ps

module tb_dual_motor_gait_phase_sequencer_top;
  import dmgps_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT, PH_LIFT, PH_PRESS, PH_WORK1, PH_WORK2
  } gait_phase_t;

  typedef struct packed {
    logic [1:0]         motor;
    logic [1:0]         prof;
    logic signed [15:0] vcmd;
    logic               clr;
    logic               last;
  } motor_cmd_t;

  // cfg rows write one register; item rows carry the command count where it
  // is plain to see (-1 leaves the count to the sequencer model)
  typedef struct packed {
    logic              cfg;
    reg_index_t        ridx;
    logic [15:0]       data;
    kind_t             k;
    logic [31:0]       t;
    logic [1:0]        id;
    logic [15:0]       v;
    logic [15:0]       p6;
    logic [15:0]       p7;
    logic signed [3:0] n_res;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en = 1'b0;
  reg_index_t         wr_index = REG_AUTO_ENABLE;
  logic [15:0]        wr_data = '0;
  logic               push = 1'b0;
  logic               full;
  kind_t              kind = KIND_SAMPLE;
  logic [31:0]        now_ms = '0;
  logic [1:0]         motor_id = MOTOR_NONE;
  logic signed [15:0] velocity = '0;
  logic [15:0]        peak_ch6 = '0;
  logic [15:0]        peak_ch7 = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [1:0]         target_motor;
  logic [1:0]         profile;
  logic signed [15:0] velocity_cmd;
  logic               clear_buffers;
  logic               last;

  dual_motor_gait_phase_sequencer_top dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .push(push), .full(full), .kind(kind), .now_ms(now_ms), .motor_id(motor_id),
    .velocity(velocity), .peak_ch6(peak_ch6), .peak_ch7(peak_ch7),
    .empty(empty), .pop(pop), .target_motor(target_motor), .profile(profile),
    .velocity_cmd(velocity_cmd), .clear_buffers(clear_buffers), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sequencer model: registers and state
  logic               auto_en;
  logic [15:0]        act_thr;
  logic [14:0]        trig;
  logic [15:0]        wait_len, idle_len, lift_to, press_to;
  logic [8:0]         vscale;
  gait_phase_t        gph;
  logic               engaged_m;
  logic [1:0]         armed_ch, lift_m, next_w;
  logic signed [15:0] cap_v;
  logic [31:0]        phase_t0, wait_t0, work_t0;

  motor_cmd_t cmd_q[$];
  motor_cmd_t new_cmds[$];
  int         errors = 0;
  bit         hold_results = 1'b0;
  bit         steady_in = 1'b0;

  plan_row_t plan [30] = '{
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd0,    MOTOR_1, 16'h7FFF, 16'h0, 16'h0, 0},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_PEAKS,  32'd10,   2'd0, 16'h0, 16'hFFFF, 16'hFFFF, 0},
    '{1'b1, REG_AUTO_ENABLE, 16'd1, KIND_SAMPLE, 32'd0,    2'd0, 16'h0, 16'h0, 16'h0, 0},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_PEAKS,  32'd1000, 2'd0, 16'h0, 16'd2560, 16'd2560, 0},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd1010, MOTOR_1, 16'h7FFF, 16'h0, 16'h0, 0},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SPARE,  32'd1020, 2'd3, 16'h0, 16'hFFFF, 16'hFFFF, 0},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_PEAKS,  32'd1030, 2'd0, 16'h0, 16'd3000, 16'd3000, 0},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd1130, MOTOR_1, 16'h7FFF, 16'h0, 16'h0, 2},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd1330, MOTOR_2, 16'h8000, 16'h0, 16'h0, 2},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd1340, MOTOR_1, 16'd513, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd1350, 2'd0, -16'sd100, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd1360, MOTOR_1, 16'h7FFF, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd1370, MOTOR_1, 16'h8000, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd1380, MOTOR_1, -16'sd200, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd1390, MOTOR_1, 16'd127, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd1400, 2'd3, 16'h0, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd1490, MOTOR_2, 16'h0, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd1600, MOTOR_2, 16'h8000, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd2100, 2'd0, 16'h0, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd2450, MOTOR_2, 16'h8000, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd2550, MOTOR_1, 16'h0, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd3750, MOTOR_1, 16'h7FFF, 16'h0, 16'h0, 2},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd3760, MOTOR_1, 16'h7FFF, 16'h0, 16'h0, 0},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_PEAKS,  32'd4000, 2'd0, 16'h0, 16'hFFFF, 16'h0, 0},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_DEACT,  32'd4010, 2'd0, 16'h0, 16'h0, 16'h0, 0},
    '{1'b1, REG_VEL_SCALE, 16'd511, KIND_SAMPLE, 32'd0,    2'd0, 16'h0, 16'h0, 16'h0, 0},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_PEAKS,  32'd5000, 2'd0, 16'h0, 16'd3000, 16'd2999, 0},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd5300, MOTOR_2, 16'h8000, 16'h0, 16'h0, -1},
    '{1'b0, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd5310, MOTOR_2, 16'h7FFF, 16'h0, 16'h0, -1},
    '{1'b1, REG_AUTO_ENABLE, 16'd0, KIND_SAMPLE, 32'd0,    2'd0, 16'h0, 16'h0, 16'h0, 0}
  };

  function automatic logic signed [15:0] scaled(logic signed [15:0] v);
    int p;
    int q;
    p = int'(v) * int'(vscale);
    q = p >>> 8;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic motor_cmd_t mk_cmd(logic [1:0] m, logic [1:0] pr, logic signed [15:0] vc,
                                        logic c);
    return '{motor: m, prof: pr, vcmd: vc, clr: c, last: 1'b0};
  endfunction

  task automatic model_reset();
    auto_en = 1'b0; act_thr = 16'd2560; trig = 15'd512; wait_len = 16'd300;
    idle_len = 16'd100; lift_to = 16'd500; press_to = 16'd350; vscale = 9'd205;
    gph = PH_IDLE; engaged_m = 1'b0; armed_ch = CH_NONE; lift_m = MOTOR_NONE;
    next_w = MOTOR_NONE; cap_v = '0; phase_t0 = '0; wait_t0 = '0; work_t0 = '0;
  endtask

  task automatic apply_reg(reg_index_t idx, logic [15:0] d);
    case (idx)
      REG_AUTO_ENABLE: begin
        auto_en = d[0];
        if (!d[0]) engaged_m = 1'b0;
      end
      REG_ACT_THRESHOLD: act_thr = d;
      REG_TRIGGER_SPEED: trig = d[14:0];
      REG_WAIT_MS:       wait_len = d;
      REG_IDLE_MS:       idle_len = d;
      REG_LIFT_TIMEOUT:  lift_to = d;
      REG_PRESS_TIMEOUT: press_to = d;
      REG_VEL_SCALE:     vscale = d[8:0];
      default: ;
    endcase
  endtask

  task automatic disengage();
    engaged_m = 1'b0;
    gph = PH_IDLE;
    armed_ch = CH_NONE;
    wait_t0 = '0;
    work_t0 = '0;
  endtask

  task automatic idle_pair(logic c);
    new_cmds.push_back(mk_cmd(MOTOR_1, PROF_IDLE, '0, c));
    new_cmds.push_back(mk_cmd(MOTOR_2, PROF_IDLE, '0, c));
  endtask

  task automatic begin_lift(logic [1:0] m, logic signed [15:0] v, logic [31:0] t);
    cap_v = v;
    gph = PH_LIFT;
    lift_m = m;
    phase_t0 = t;
    new_cmds.push_back(mk_cmd(m, PROF_LIFT, scaled(v), 1'b0));
  endtask

  // advance the sequencer model by one item and queue the commands it causes
  task automatic step_sequencer(kind_t k, logic [31:0] t, logic [1:0] id,
                                logic signed [15:0] v, logic [15:0] p6, logic [15:0] p7,
                                output int n);
    int          tv;
    int          vi;
    logic        a6, a7, go, id_match;
    logic [31:0] el;
    motor_cmd_t  c;
    new_cmds.delete();
    tv = int'(trig);
    vi = int'(v);
    id_match = (lift_m == MOTOR_1 && id == MOTOR_1) || (lift_m == MOTOR_2 && id == MOTOR_2);
    if (k == KIND_PEAKS) begin
      a6 = p6 > act_thr;
      a7 = p7 > act_thr;
      if (auto_en && !engaged_m && (a6 || a7)) begin
        if (a6 && a7) armed_ch = (p6 > p7) ? CH_6 : CH_7;
        else armed_ch = a6 ? CH_6 : CH_7;
        engaged_m = 1'b1;
        gph = PH_WAIT;
        wait_t0 = t;
      end
    end else if (k == KIND_DEACT) begin
      if (engaged_m) disengage();
    end else if (k == KIND_SAMPLE && engaged_m) begin
      case (gph)
        PH_WAIT: begin
          idle_pair(1'b0);
          el = t - wait_t0;
          if (el >= 32'(wait_len)) begin
            if (armed_ch == CH_6 && id == MOTOR_2 && vi < -tv) begin
              next_w = MOTOR_1;
              begin_lift(MOTOR_2, v, t);
            end else if (armed_ch == CH_7 && id == MOTOR_1 && vi > tv) begin
              next_w = MOTOR_2;
              begin_lift(MOTOR_1, v, t);
            end
          end
        end
        PH_WORK1, PH_WORK2: begin
          el = t - work_t0;
          if (el >= WORK_TIMEOUT_MS) begin
            idle_pair(1'b1);
            disengage();
          end else begin
            idle_pair(1'b0);
            if (gph == PH_WORK1 && id == MOTOR_1 && vi > tv) begin_lift(MOTOR_1, v, t);
            else if (gph == PH_WORK2 && id == MOTOR_2 && vi < -tv) begin_lift(MOTOR_2, v, t);
          end
        end
        PH_LIFT: begin
          go = 1'b0;
          el = t - phase_t0;
          if (el >= 32'(lift_to)) go = 1'b1;
          else if (lift_m == MOTOR_1 && id == MOTOR_1) go = (cap_v > 0 && v < 0);
          else if (lift_m == MOTOR_2 && id == MOTOR_2) go = (cap_v < 0 && v > 0);
          if (go) begin
            next_w = (lift_m == MOTOR_1) ? MOTOR_2 : MOTOR_1;
            gph = PH_PRESS;
            phase_t0 = t;
            if (id_match) new_cmds.push_back(mk_cmd(lift_m, PROF_PRESS, scaled(v), 1'b0));
          end else if (id_match) begin
            new_cmds.push_back(mk_cmd(lift_m, PROF_LIFT, scaled(v), 1'b0));
          end
        end
        PH_PRESS: begin
          go = 1'b0;
          el = t - phase_t0;
          if (el >= 32'(press_to)) go = 1'b1;
          else if (id_match)
            go = (vi > -int'(PRESS_DONE_SPEED)) && (vi < int'(PRESS_DONE_SPEED));
          if (go) begin
            gph = PH_IDLE;
            lift_m = MOTOR_NONE;
            phase_t0 = t;
            idle_pair(1'b0);
          end else if (id_match) begin
            new_cmds.push_back(mk_cmd(lift_m, PROF_PRESS, scaled(v), 1'b0));
          end
        end
        PH_IDLE: begin
          el = t - phase_t0;
          if (el >= 32'(idle_len)) begin
            gph = (next_w == MOTOR_1) ? PH_WORK1 : PH_WORK2;
            phase_t0 = t;
            work_t0 = t;
          end
          idle_pair(1'b0);
        end
        default: ;
      endcase
    end
    n = new_cmds.size();
    for (int i = 0; i < n; i++) begin
      c = new_cmds[i];
      c.last = (i == n - 1);
      cmd_q.push_back(c);
    end
  endtask

  task automatic send(kind_t k, logic [31:0] t, logic [1:0] id, logic signed [15:0] v,
                      logic [15:0] p6, logic [15:0] p7, output int n);
    int gap;
    int r;
    gap = 0;
    if (!steady_in) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(8, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind <= k;
    now_ms <= t;
    motor_id <= id;
    velocity <= v;
    peak_ch6 <= p6;
    peak_ch7 <= p7;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    step_sequencer(k, t, id, v, p6, p7, n);
  endtask

  // drop push, wait for every command, then let the block go quiet
  task automatic settle();
    push <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] d);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= d;
    @(posedge clk);
    apply_reg(idx, d);
  endtask

  function automatic logic [15:0] pick_len(int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, hi));
  endfunction

  task automatic check_cmd();
    motor_cmd_t e;
    if (cmd_q.size() == 0) begin
      $error("unexpected command: target_motor %0d profile %0d velocity_cmd %0d",
             target_motor, profile, velocity_cmd);
      errors++;
    end else begin
      e = cmd_q.pop_front();
      if (target_motor !== e.motor) begin
        $error("target_motor: expected %0d, got %0d", e.motor, target_motor);
        errors++;
      end
      if (profile !== e.prof) begin
        $error("profile: expected %0d, got %0d", e.prof, profile);
        errors++;
      end
      if (velocity_cmd !== e.vcmd) begin
        $error("velocity_cmd: expected %0d, got %0d", $signed(e.vcmd), velocity_cmd);
        errors++;
      end
      if (clear_buffers !== e.clr) begin
        $error("clear_buffers: expected %0d, got %0d", e.clr, clear_buffers);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, last);
        errors++;
      end
    end
  endtask

  // result side: random stalls, steady stretches, one long hold on request
  initial begin
    int stall;
    int r;
    bit steady_out;
    stall = 0;
    steady_out = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (pop && !empty) check_cmd();
      if (hold_results) begin
        hold_results = 1'b0;
        pop <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) steady_out = !steady_out;
        r = $urandom_range(0, 99);
        if (steady_out || r < 70) begin
          pop <= 1'b1;
        end else begin
          stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
          pop <= 1'b0;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int                 n;
    int                 r;
    int                 lo;
    logic [31:0]        t_now;
    logic [15:0]        regs [8];
    kind_t              k;
    logic [1:0]         id;
    logic signed [15:0] v;
    logic [15:0]        p6, p7;
    model_reset();
    t_now = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        settle();
        write_reg(plan[i].ridx, plan[i].data);
        wr_en <= 1'b0;
      end else begin
        send(plan[i].k, plan[i].t, plan[i].id, plan[i].v, plan[i].p6, plan[i].p7, n);
        if (plan[i].n_res >= 0 && n != plan[i].n_res) begin
          $error("commands for plan row %0d: expected %0d, got %0d", i, plan[i].n_res, n);
          errors++;
        end
      end
    end
    t_now = 32'd6000;

    for (int ph = 0; ph < 12; ph++) begin
      settle();
      regs[REG_AUTO_ENABLE]   = 16'($urandom_range(0, 7) != 0);
      regs[REG_ACT_THRESHOLD] = pick_len(4000);
      regs[REG_TRIGGER_SPEED] = ($urandom_range(0, 9) == 0) ? 16'hFFFF :
                                16'($urandom_range(0, 3000));
      regs[REG_WAIT_MS]       = pick_len(400);
      regs[REG_IDLE_MS]       = pick_len(300);
      regs[REG_LIFT_TIMEOUT]  = pick_len(600);
      regs[REG_PRESS_TIMEOUT] = pick_len(500);
      regs[REG_VEL_SCALE]     = 16'($urandom_range(0, 511));
      if (ph == 1) begin
        regs[REG_AUTO_ENABLE] = 16'd1;
        regs[REG_ACT_THRESHOLD] = 16'd0;
        regs[REG_TRIGGER_SPEED] = 16'd0;
        regs[REG_WAIT_MS] = 16'd0;
        regs[REG_IDLE_MS] = 16'd0;
        regs[REG_LIFT_TIMEOUT] = 16'd0;
        regs[REG_PRESS_TIMEOUT] = 16'd0;
        regs[REG_VEL_SCALE] = 16'd256;
      end else if (ph == 2) begin
        regs[REG_AUTO_ENABLE] = 16'hFFFF;
        regs[REG_ACT_THRESHOLD] = 16'hFFFF;
        regs[REG_TRIGGER_SPEED] = 16'hFFFF;
        regs[REG_WAIT_MS] = 16'hFFFF;
        regs[REG_IDLE_MS] = 16'hFFFF;
        regs[REG_LIFT_TIMEOUT] = 16'hFFFF;
        regs[REG_PRESS_TIMEOUT] = 16'hFFFF;
        regs[REG_VEL_SCALE] = 16'h01FF;
      end else if (ph == 3) begin
        regs[REG_VEL_SCALE] = 16'd0;
      end
      for (int ri = 0; ri < 8; ri++) write_reg(reg_index_t'(ri), regs[ri]);
      wr_en <= 1'b0;

      steady_in = (ph % 3 == 2);
      if (ph == 4) hold_results = 1'b1;
      if ($urandom_range(0, 3) == 0) t_now = 32'hFFFF_FFFF - $urandom_range(0, 2000);

      for (int j = 0; j < 30; j++) begin
        // hold the sender until every command has come out
        if (ph == 7 && j == 15) begin
          push <= 1'b0;
          do @(posedge clk); while (cmd_q.size() != 0);
        end
        r = $urandom_range(0, 99);
        if (r < 70) t_now += $urandom_range(0, 120);
        else if (r < 95) t_now += $urandom_range(100, 700);
        else if (r < 99) t_now += $urandom_range(1000, 2500);
        else t_now = $urandom();

        id = 2'($urandom_range(0, 3));
        v = 16'($urandom());
        p6 = 16'($urandom());
        p7 = 16'($urandom());
        r = $urandom_range(0, 99);
        if (!engaged_m && r < 70) begin
          k = KIND_PEAKS;
          if (act_thr != 16'hFFFF) begin
            p6 = 16'($urandom_range(int'(act_thr) + 1, 65535));
            p7 = $urandom_range(0, 1) ? 16'($urandom_range(int'(act_thr) + 1, 65535)) :
                                        16'($urandom_range(0, int'(act_thr)));
            if ($urandom_range(0, 1)) {p6, p7} = {p7, p6};
          end
        end else if (r < 6) begin
          k = KIND_PEAKS;
        end else if (r < 8) begin
          k = KIND_DEACT;
        end else if (r < 10) begin
          k = KIND_SPARE;
        end else begin
          k = KIND_SAMPLE;
          if ($urandom_range(0, 9) != 0) id = $urandom_range(0, 1) ? MOTOR_1 : MOTOR_2;
          lo = int'(trig) + 1;
          r = $urandom_range(0, 9);
          if (r < 4) v = 16'($urandom_range((lo > 32767) ? 32767 : lo, 32767));
          else if (r < 8) v = 16'(-int'($urandom_range(lo, 32768)));
          else if (r < 9) v = 16'(int'($urandom_range(0, 254)) - 127);
        end
        send(k, t_now, id, v, p6, p7, n);
      end
    end

    push <= 1'b0;
    do @(posedge clk); while (cmd_q.size() != 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && cmd_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/dmgps_pkg.sv
src/dmgps_front.sv
src/dmgps_queue.sv
src/dmgps_back.sv
src/dual_motor_gait_phase_sequencer_top.sv
src/dmgps_checker.sv
verif/tb_dual_motor_gait_phase_sequencer_top.sv
